// ===== rtl/core/dht_pkg.sv =====
// Shared types and codes for the double-hashing table.
// Used by dht_probe and double_hash_table; depends on nothing.
`default_nettype none

package dht_pkg;

    // Width of the key port as seen at the top level
    localparam int KEY_PORT_W = 16;
    // Width of the reported slot number
    localparam int SLOT_PORT_W = 4;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_INSERTED    = 3'd0,
        ST_FULL        = 3'd1,
        ST_FOUND       = 3'd2,
        ST_NOT_FOUND   = 3'd3,
        ST_DELETED     = 3'd4,
        ST_DEL_MISSING = 3'd5
    } t_status;

    // Sequencer to probe engine
    typedef struct packed {
        logic start;
        t_op  op;
    } t_probe_ctl;

    // Probe engine to sequencer
    typedef struct packed {
        logic init_done;
        logic done;
        logic hit;
    } t_probe_sts;

endpackage

`default_nettype wire

// ===== rtl/core/dht_hash.sv =====
// Remainder unit: home slot (key mod TABLE_SIZE) and probe stride
// ((SECOND_MOD - key mod SECOND_MOD) mod TABLE_SIZE) by reciprocal multiplication.
// Pipeline of quotient, remainder, stride quotient and stride registers. No package use.
`default_nettype none

module dht_hash #(
    parameter int TABLE_SIZE = 16,
    parameter int SECOND_MOD = 7,
    parameter int KW         = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [KW-1:0]                 i_key,
    output logic                               o_done,
    output logic [$clog2(TABLE_SIZE)-1:0]      o_pos,
    output logic [$clog2(TABLE_SIZE)-1:0]      o_stride
);

    localparam int TW = $clog2(TABLE_SIZE);
    localparam int SW = $clog2(SECOND_MOD);
    localparam int DW = $clog2(SECOND_MOD + 1);

    // Shift amounts: dividend bits plus ceil(log2(divisor)) keeps the quotient exact
    localparam int SH_T = KW + TW;
    localparam int SH_S = KW + SW;
    localparam int SH_D = DW + TW;

    localparam int MW_K = KW + 2;
    localparam int MW_D = DW + 2;
    localparam int PW_T = SH_T + KW + 2;
    localparam int PW_S = SH_S + KW + 2;
    localparam int PW_D = SH_D + DW + 2;

    // Rounded-up reciprocals
    localparam logic [MW_K-1:0] M_T =
        MW_K'(((64'd1 << SH_T) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
    localparam logic [MW_K-1:0] M_S =
        MW_K'(((64'd1 << SH_S) + 64'(SECOND_MOD) - 64'd1) / 64'(SECOND_MOD));
    localparam logic [MW_D-1:0] M_D =
        MW_D'(((64'd1 << SH_D) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));

    // Divisors at operand width; a divisor above the operand range meets a zero quotient
    localparam logic [KW-1:0] T_K = KW'(TABLE_SIZE);
    localparam logic [KW-1:0] S_K = KW'(SECOND_MOD);
    localparam logic [DW-1:0] S_D = DW'(SECOND_MOD);
    localparam logic [DW-1:0] T_D = DW'(TABLE_SIZE);

    logic [2:0]       r_v;
    logic             r_done;
    logic [KW-1:0]    r_key;
    logic [KW-1:0]    r_qt;
    logic [KW-1:0]    r_qs;
    logic [DW-1:0]    r_dterm;
    logic [DW-1:0]    r_qd;
    logic [TW-1:0]    r_pos;
    logic [TW-1:0]    r_stride;

    logic [PW_T-1:0]  prod_t;
    logic [PW_S-1:0]  prod_s;
    logic [PW_D-1:0]  prod_d;
    logic [KW-1:0]    rem_t;
    logic [KW-1:0]    rem_s;

    // Quotient products and remainders
    always_comb begin
        prod_t = PW_T'(i_key) * PW_T'(M_T);
        prod_s = PW_S'(i_key) * PW_S'(M_S);
        prod_d = PW_D'(r_dterm) * PW_D'(M_D);
        rem_t  = r_key - r_qt * T_K;
        rem_s  = r_key - r_qs * S_K;
    end

    // Pipeline: quotients, home slot and stride term, stride quotient, stride
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_done <= 1'b0;
        end else begin
            r_v    <= {r_v[1:0], i_start};
            r_done <= r_v[2];
            if (i_start) begin
                r_key <= i_key;
                r_qt  <= prod_t[SH_T +: KW];
                r_qs  <= prod_s[SH_S +: KW];
            end
            if (r_v[0]) begin
                r_pos   <= TW'(rem_t);
                r_dterm <= S_D - DW'(rem_s);
            end
            if (r_v[1]) begin
                r_qd <= prod_d[SH_D +: DW];
            end
            if (r_v[2]) begin
                r_stride <= TW'(r_dterm - r_qd * T_D);
            end
        end
    end

    assign o_done   = r_done;
    assign o_pos    = r_pos;
    assign o_stride = r_stride;

endmodule

`default_nettype wire

// ===== rtl/core/dht_probe.sv =====
// Probe engine: slot memory, clearing pass after reset, and the probe walk.
// Depends on dht_pkg for the op codes and the control/status structs.
`default_nettype none

module dht_probe #(
    parameter int TABLE_SIZE = 16,
    parameter int KW         = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dht_pkg::t_probe_ctl           i_ctl,
    input  wire logic [KW-1:0]                 i_key,
    input  wire logic [$clog2(TABLE_SIZE)-1:0] i_pos,
    input  wire logic [$clog2(TABLE_SIZE)-1:0] i_stride,
    output dht_pkg::t_probe_sts                o_sts,
    output logic [$clog2(TABLE_SIZE)-1:0]      o_slot
);

    localparam int TW = $clog2(TABLE_SIZE);
    localparam int IW = $clog2(TABLE_SIZE + 1);

    localparam logic [TW:0]   T_C    = (TW + 1)'(TABLE_SIZE);
    localparam logic [IW-1:0] T_CNT  = IW'(TABLE_SIZE);
    localparam logic [TW-1:0] T_LAST = TW'(TABLE_SIZE - 1);

    typedef enum logic [1:0] {
        P_CLEAR,
        P_IDLE,
        P_WALK
    } t_pstate;

    // Entry layout: valid bit on top of the key
    logic [KW:0]      r_mem [TABLE_SIZE];
    logic [KW:0]      r_rdata;

    t_pstate          r_state;
    dht_pkg::t_op     r_op;
    logic [KW-1:0]    r_key;
    logic [TW-1:0]    r_stride;
    logic [TW-1:0]    r_pos;
    logic [TW-1:0]    r_cmp_pos;
    logic             r_cmp_v;
    logic [IW-1:0]    r_issued;
    logic             r_done;
    logic             r_hit;
    logic [TW-1:0]    r_slot;

    logic [TW:0]      pos_sum;
    logic [TW-1:0]    n_pos;
    logic             eval_hit;
    logic             mem_we;
    logic [TW-1:0]    mem_addr;
    logic [KW:0]      mem_wdata;

    // Next slot on the path: both terms are below TABLE_SIZE
    always_comb begin
        pos_sum = {1'b0, r_pos} + {1'b0, r_stride};
        n_pos   = (pos_sum >= T_C) ? TW'(pos_sum - T_C) : pos_sum[TW-1:0];
    end

    // Check the entry read in the previous cycle
    always_comb begin
        eval_hit = 1'b0;
        if (r_state == P_WALK && r_cmp_v) begin
            if (r_op == dht_pkg::OP_INSERT) begin
                eval_hit = !r_rdata[KW];
            end else begin
                eval_hit = r_rdata[KW] && (r_rdata[KW-1:0] == r_key);
            end
        end
    end

    // Memory port: clearing writes, probe reads, final update
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_pos;
        mem_wdata = '0;
        unique case (r_state)
            P_CLEAR: begin
                mem_we = 1'b1;
            end
            P_WALK: begin
                if (eval_hit && r_op != dht_pkg::OP_SEARCH) begin
                    mem_we    = 1'b1;
                    mem_addr  = r_cmp_pos;
                    mem_wdata = {(r_op == dht_pkg::OP_INSERT), r_key};
                end
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

    // Clearing pass, probe walk and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_CLEAR;
            r_pos   <= '0;
            r_cmp_v <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                P_CLEAR: begin
                    r_pos <= r_pos + 1'b1;
                    if (r_pos == T_LAST) begin
                        r_state <= P_IDLE;
                    end
                end
                P_IDLE: begin
                    if (i_ctl.start) begin
                        r_op     <= i_ctl.op;
                        r_key    <= i_key;
                        r_stride <= i_stride;
                        r_pos    <= i_pos;
                        r_issued <= '0;
                        r_cmp_v  <= 1'b0;
                        r_state  <= P_WALK;
                    end
                end
                P_WALK: begin
                    if (eval_hit) begin
                        r_done  <= 1'b1;
                        r_hit   <= 1'b1;
                        r_slot  <= r_cmp_pos;
                        r_cmp_v <= 1'b0;
                        r_state <= P_IDLE;
                    end else if (!r_cmp_v && r_issued == T_CNT) begin
                        // whole path seen, nothing matched
                        r_done  <= 1'b1;
                        r_hit   <= 1'b0;
                        r_slot  <= '0;
                        r_state <= P_IDLE;
                    end else if (r_issued != T_CNT) begin
                        r_cmp_pos <= r_pos;
                        r_cmp_v   <= 1'b1;
                        r_pos     <= n_pos;
                        r_issued  <= r_issued + 1'b1;
                    end else begin
                        r_cmp_v <= 1'b0;
                    end
                end
                default: r_state <= P_IDLE;
            endcase
        end
    end

    assign o_sts.init_done = (r_state != P_CLEAR);
    assign o_sts.done      = r_done;
    assign o_sts.hit       = r_hit;
    assign o_slot          = r_slot;

endmodule

`default_nettype wire

// ===== rtl/core/double_hash_table.sv =====
// Top level of the double-hashing table: command sequencer and result register.
// Instantiates dht_hash and dht_probe; depends on dht_pkg.
//
//  channel   | signals                     | handshake
//  ----------+-----------------------------+----------------------------------
//  command   | i_op, i_key                 | taken when start high, busy low
//  result    | o_status, o_slot            | o_valid high for one cycle
//
// An op of 3 is answered in the cycle after it is taken, without a table access. Other
// ops pass from accept to result through the hash start register, four remainder stages,
// the probe start register, one slot read per cycle and the compare, miss and result
// registers. Busy drops together with the result, so the next item can be taken while
// the result is shown. After reset busy stays high while the memory is cleared.
// Results cannot be stalled; each is shown for exactly one cycle.
`default_nettype none

module double_hash_table #(
    parameter int TABLE_SIZE = 16,
    parameter int SECOND_MOD = 7,
    parameter int KEY_WIDTH  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_op,
    input  wire logic [dht_pkg::KEY_PORT_W-1:0] i_key,
    output logic                               o_valid,
    output logic [2:0]                         o_status,
    output logic [dht_pkg::SLOT_PORT_W-1:0]    o_slot
);

    localparam int KW = (KEY_WIDTH < dht_pkg::KEY_PORT_W) ? KEY_WIDTH : dht_pkg::KEY_PORT_W;
    localparam int TW = $clog2(TABLE_SIZE);

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_PROBE
    } t_state;

    t_state                          r_state;
    dht_pkg::t_op                    r_op;
    logic [KW-1:0]                   r_key;
    logic                            r_hstart;
    logic                            r_pstart;
    logic                            r_valid;
    dht_pkg::t_status                r_status;
    logic [dht_pkg::SLOT_PORT_W-1:0] r_slot;

    logic                            h_done;
    logic [TW-1:0]                   h_pos;
    logic [TW-1:0]                   h_stride;
    dht_pkg::t_probe_ctl             p_ctl;
    dht_pkg::t_probe_sts             p_sts;
    logic [TW-1:0]                   p_slot;
    logic                            accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    dht_hash #(
        .TABLE_SIZE (TABLE_SIZE),
        .SECOND_MOD (SECOND_MOD),
        .KW         (KW)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_hstart),
        .i_key    (r_key),
        .o_done   (h_done),
        .o_pos    (h_pos),
        .o_stride (h_stride)
    );

    assign p_ctl.start = r_pstart;
    assign p_ctl.op    = r_op;

    dht_probe #(
        .TABLE_SIZE (TABLE_SIZE),
        .KW         (KW)
    ) u_probe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (p_ctl),
        .i_key    (r_key),
        .i_pos    (h_pos),
        .i_stride (h_stride),
        .o_sts    (p_sts),
        .o_slot   (p_slot)
    );

    // Command sequencer with registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_hstart <= 1'b0;
            r_pstart <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_hstart <= 1'b0;
            r_pstart <= 1'b0;
            r_valid  <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    if (p_sts.init_done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op  <= dht_pkg::t_op'(i_op);
                        r_key <= i_key[KW-1:0];
                        if (dht_pkg::t_op'(i_op) == dht_pkg::OP_NONE) begin
                            // unknown op: no table access
                            r_valid  <= 1'b1;
                            r_status <= dht_pkg::ST_NOT_FOUND;
                            r_slot   <= '0;
                        end else begin
                            r_hstart <= 1'b1;
                            r_state  <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    if (h_done) begin
                        r_pstart <= 1'b1;
                        r_state  <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (p_sts.done) begin
                        r_valid <= 1'b1;
                        r_slot  <= p_sts.hit ? dht_pkg::SLOT_PORT_W'(p_slot) : '0;
                        unique case (r_op)
                            dht_pkg::OP_INSERT:
                                r_status <= p_sts.hit ? dht_pkg::ST_INSERTED
                                                      : dht_pkg::ST_FULL;
                            dht_pkg::OP_SEARCH:
                                r_status <= p_sts.hit ? dht_pkg::ST_FOUND
                                                      : dht_pkg::ST_NOT_FOUND;
                            default:
                                r_status <= p_sts.hit ? dht_pkg::ST_DELETED
                                                      : dht_pkg::ST_DEL_MISSING;
                        endcase
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_slot   = r_slot;

endmodule

`default_nettype wire

// ===== tb/tb_double_hash_table.sv =====
// Self-checking bench for double_hash_table: insert, search and delete items
// run against a shadow table kept in the bench. Depends on dht_pkg and the RTL.
`timescale 1ns / 100ps

module tb_double_hash_table;

    // Geometry of the block as built with its default parameters
    localparam int TBL_SLOTS  = 16;
    localparam int STRIDE_MOD = 7;
    localparam int TAIL_ITEMS = 60;
    localparam int PHASE_LEN  = 100;
    localparam int NUM_PHASES = 5;

    typedef struct {
        dht_pkg::t_op op;
        logic [15:0]  key;
        bit           drain;     // hold off until every reply is back
    } t_table_cmd;

    typedef struct {
        dht_pkg::t_status status;
        logic [3:0]       slot;
    } t_table_reply;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic [1:0]  i_op    = '0;
    logic [15:0] i_key   = '0;
    logic        busy;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [3:0]  o_slot;

    t_table_cmd   pending_cmds[$];
    t_table_reply awaited_replies[$];
    logic [15:0]  used_keys[$];
    int           items_issued  = 0;
    int           replies_seen  = 0;
    int           mismatch_count = 0;
    int           idle_left     = 0;

    // Shadow copy of the slot store
    logic [15:0] shadow_keys  [TBL_SLOTS];
    bit          shadow_valid [TBL_SLOTS];

    double_hash_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_op     (i_op),
        .i_key    (i_key),
        .o_valid  (o_valid),
        .o_status (o_status),
        .o_slot   (o_slot)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Walk the probe path of one key and apply the op to the shadow table
    task automatic apply_table_op(input dht_pkg::t_op op, input logic [15:0] key,
                                  output t_table_reply reply);
        int pos;
        int stride;
        int hit_slot;
        int free_slot;
        pos       = key % TBL_SLOTS;
        stride    = (STRIDE_MOD - key % STRIDE_MOD) % TBL_SLOTS;
        hit_slot  = -1;
        free_slot = -1;
        for (int i = 0; i < TBL_SLOTS; i++) begin
            if (shadow_valid[pos] && shadow_keys[pos] == key && hit_slot < 0)
                hit_slot = pos;
            if (!shadow_valid[pos] && free_slot < 0)
                free_slot = pos;
            pos = (pos + stride) % TBL_SLOTS;
        end
        reply.status = dht_pkg::ST_NOT_FOUND;
        reply.slot   = '0;
        case (op)
            dht_pkg::OP_INSERT: begin
                if (free_slot < 0) begin
                    reply.status = dht_pkg::ST_FULL;
                end else begin
                    shadow_keys[free_slot]  = key;
                    shadow_valid[free_slot] = 1'b1;
                    reply.status = dht_pkg::ST_INSERTED;
                    reply.slot   = free_slot[3:0];
                end
            end
            dht_pkg::OP_SEARCH: begin
                if (hit_slot >= 0) begin
                    reply.status = dht_pkg::ST_FOUND;
                    reply.slot   = hit_slot[3:0];
                end
            end
            dht_pkg::OP_DELETE: begin
                if (hit_slot < 0) begin
                    reply.status = dht_pkg::ST_DEL_MISSING;
                end else begin
                    shadow_valid[hit_slot] = 1'b0;
                    reply.status = dht_pkg::ST_DELETED;
                    reply.slot   = hit_slot[3:0];
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_cmd(input dht_pkg::t_op op, input logic [15:0] key,
                             input bit drain);
        t_table_cmd cmd;
        cmd.op    = op;
        cmd.key   = key;
        cmd.drain = drain;
        pending_cmds.push_back(cmd);
    endtask

    task automatic report_mismatch(input string what, input t_table_reply want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected status %0d slot %0d, got status %0d slot %0d",
                     $realtime, what, want.status, want.slot, o_status, o_slot);
    endtask

    // Driver: presents queued items, predicts each reply when it is taken
    always @(posedge i_clk) begin : drive_cmds
        logic         next_start;
        t_table_cmd   cmd;
        t_table_reply reply;
        next_start = start;
        if (!i_rst_n) begin
            next_start = 1'b0;
            idle_left  = 0;
        end else begin
            if (start && !busy) begin
                apply_table_op(dht_pkg::t_op'(i_op), i_key, reply);
                awaited_replies.push_back(reply);
                items_issued++;
                next_start = 1'b0;
            end
            if (!next_start) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (pending_cmds.size() != 0 &&
                             (!pending_cmds[0].drain || items_issued == replies_seen)) begin
                    cmd = pending_cmds.pop_front();
                    i_op  <= cmd.op;
                    i_key <= cmd.key;
                    next_start = 1'b1;
                    // bursty gaps, none near the end
                    if (pending_cmds.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0)
                        idle_left = $urandom_range(1, 14);
                end
            end
        end
        start <= next_start;
    end

    // Monitor: every strobed reply must match the oldest prediction
    always @(posedge i_clk) begin : check_replies
        t_table_reply want;
        if (i_rst_n && o_valid === 1'b1) begin
            replies_seen <= replies_seen + 1;
            if (awaited_replies.size() == 0) begin
                want.status = dht_pkg::ST_NOT_FOUND;
                want.slot   = '0;
                report_mismatch("reply with nothing pending", want);
            end else begin
                want = awaited_replies.pop_front();
                if (o_status !== want.status || o_slot !== want.slot)
                    report_mismatch("reply mismatch", want);
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        int           r;
        logic [15:0]  k;
        dht_pkg::t_op op;

        // Empty table, the unused op, key extremes
        queue_cmd(dht_pkg::OP_SEARCH, 16'h0000, 1'b0);
        queue_cmd(dht_pkg::OP_DELETE, 16'hFFFF, 1'b0);
        queue_cmd(dht_pkg::OP_NONE,   16'hFFFF, 1'b0);
        queue_cmd(dht_pkg::OP_NONE,   16'h0000, 1'b0);
        queue_cmd(dht_pkg::OP_INSERT, 16'h0000, 1'b0);
        queue_cmd(dht_pkg::OP_INSERT, 16'hFFFF, 1'b0);
        queue_cmd(dht_pkg::OP_SEARCH, 16'hFFFF, 1'b0);
        // Duplicate key; search must walk past the freed slot
        queue_cmd(dht_pkg::OP_INSERT, 16'h0000, 1'b0);
        queue_cmd(dht_pkg::OP_DELETE, 16'h0000, 1'b0);
        queue_cmd(dht_pkg::OP_SEARCH, 16'h0000, 1'b0);
        queue_cmd(dht_pkg::OP_DELETE, 16'h0000, 1'b0);
        queue_cmd(dht_pkg::OP_DELETE, 16'h0000, 1'b0);
        // Keys 3 + 112n share a four-slot path (3, 7, 11, 15); fill it up
        queue_cmd(dht_pkg::OP_INSERT, 16'd3,   1'b0);
        queue_cmd(dht_pkg::OP_INSERT, 16'd115, 1'b0);
        queue_cmd(dht_pkg::OP_INSERT, 16'd227, 1'b0);
        queue_cmd(dht_pkg::OP_INSERT, 16'd339, 1'b0);
        queue_cmd(dht_pkg::OP_SEARCH, 16'd339, 1'b0);
        queue_cmd(dht_pkg::OP_DELETE, 16'hFFFF, 1'b1);
        queue_cmd(dht_pkg::OP_INSERT, 16'd339, 1'b0);
        queue_cmd(dht_pkg::OP_INSERT, 16'd451, 1'b0);
        queue_cmd(dht_pkg::OP_DELETE, 16'd115, 1'b0);
        queue_cmd(dht_pkg::OP_INSERT, 16'd451, 1'b0);
        queue_cmd(dht_pkg::OP_SEARCH, 16'd227, 1'b0);
        queue_cmd(dht_pkg::OP_INSERT, 16'h8000, 1'b0);
        queue_cmd(dht_pkg::OP_NONE,   16'h5A5A, 1'b0);
        used_keys = '{16'd0, 16'hFFFF, 16'd3, 16'd115, 16'd227, 16'd339, 16'd451};

        // Random phases alternate between filling and draining the table
        for (int p = 0; p < NUM_PHASES; p++) begin
            for (int n = 0; n < PHASE_LEN; n++) begin
                r = $urandom_range(0, 99);
                if (p % 2 == 0)
                    op = (r < 55) ? dht_pkg::OP_INSERT : (r < 80) ? dht_pkg::OP_SEARCH :
                         (r < 95) ? dht_pkg::OP_DELETE : dht_pkg::OP_NONE;
                else
                    op = (r < 20) ? dht_pkg::OP_INSERT : (r < 45) ? dht_pkg::OP_SEARCH :
                         (r < 95) ? dht_pkg::OP_DELETE : dht_pkg::OP_NONE;
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    k = used_keys[$urandom_range(0, used_keys.size() - 1)];
                end else begin
                    k = 16'($urandom_range(0, 65535));
                    // cluster some keys on one home slot
                    if (r < 70)
                        k[3:0] = 4'd9;
                    used_keys.push_back(k);
                end
                queue_cmd(op, k, n == 0);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_cmds.size() != 0 || start || items_issued != replies_seen);
        repeat (60) @(posedge i_clk);

        if (mismatch_count == 0 && awaited_replies.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/dht_pkg.sv
rtl/core/dht_hash.sv
rtl/core/dht_probe.sv
rtl/core/double_hash_table.sv
tb/tb_double_hash_table.sv
